// ----- design/joystick_input_conditioner_assert.svh -----
// Assertion macros shared by the joystick input conditioner RTL.
`ifndef JOYSTICK_INPUT_CONDITIONER_ASSERT_SVH
`define JOYSTICK_INPUT_CONDITIONER_ASSERT_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset
`define JIC_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition in one cycle implies a consequence in the next
`define JIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define JIC_ASSERT_CLK(lbl, prop, msg)
`define JIC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- design/jic_pkg.sv -----
// Shared types and constants for the joystick input conditioner.
package jic_pkg;

  // Default number of fraction bits of the stick and length outputs
  localparam int FRAC_BITS_DEF = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BTN_MASK  = 2'd3;

  // Register values after reset
  localparam logic [6:0]  DEAD_ZONE_RST = 7'd8;
  localparam logic [6:0]  OFFSET_RST    = 7'd6;
  localparam logic [6:0]  RADIUS_RST    = 7'd64;
  localparam logic [15:0] BTN_MASK_RST  = 16'hFFFF;

  // One controller poll
  typedef struct packed {
    logic               connected;
    logic signed [7:0]  raw_x;
    logic signed [7:0]  raw_y;
    logic [15:0]        buttons_raw;
  } in_word_t;

  // One conditioned result
  typedef struct packed {
    logic [15:0]        buttons_held;
    logic [15:0]        buttons_new;
    logic signed [15:0] stick_x_out;
    logic signed [15:0] stick_y_out;
    logic [14:0]        stick_length;
  } out_word_t;

  // Control into and status out of the bit-serial units
  typedef struct packed {
    logic start;
  } ser_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ser_sts_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SQRT,
    ST_DIV_X,
    ST_DIV_Y,
    ST_DONE
  } jic_state_t;

endpackage

// ----- design/jic_sqrt.sv -----
// Bit-serial integer square root: two radicand bits in, one root bit out per cycle.
module jic_sqrt #(
  parameter int ROOT_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  jic_pkg::ser_ctl_t ctl,
  input  logic [15:0]       radicand,
  output jic_pkg::ser_sts_t sts,
  output logic [ROOT_W-1:0] root
);
  import jic_pkg::*;

  localparam int RAD_W = 2 * ROOT_W;
  localparam int CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad_sh_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [ROOT_W+3:0] trial;
  logic [ROOT_W+3:0] sub;
  logic [ROOT_W+3:0] diff;
  logic              ge;
  logic              last;

  // One restoring step: bring down two bits, try 4*root+1
  assign trial = {rem_r, rad_sh_r[RAD_W-1 -: 2]};
  assign sub   = {2'b00, root_r, 2'b01};
  assign ge    = trial >= sub;
  assign diff  = trial - sub;
  assign last  = cnt_r == CNT_W'(ROOT_W - 1);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rad_sh_r <= RAD_W'(radicand) << (RAD_W - 16);
      rem_r    <= '0;
      root_r   <= '0;
    end else if (busy_r) begin
      rad_sh_r <= rad_sh_r << 2;
      rem_r    <= ge ? diff[ROOT_W+1:0] : trial[ROOT_W+1:0];
      root_r   <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign root     = root_r;

endmodule

// ----- design/jic_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
module jic_div #(
  parameter int QUO_W = 15,
  parameter int DEN_W = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  jic_pkg::ser_ctl_t       ctl,
  input  logic [DEN_W+QUO_W-1:0]  dividend,
  input  logic [DEN_W-1:0]        divisor,
  output jic_pkg::ser_sts_t       sts,
  output logic [QUO_W-1:0]        quotient
);
  import jic_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] q_sh_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic             last;

  // Bring down the next dividend bit and try the divisor
  assign trial = {rem_r, q_sh_r[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};
  assign last  = cnt_r == CNT_W'(QUO_W - 1);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Upper dividend part seeds the remainder; the lower part shifts through
  // and is replaced by quotient bits.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      den_r  <= divisor;
      rem_r  <= dividend[DEN_W+QUO_W-1:QUO_W];
      q_sh_r <= dividend[QUO_W-1:0];
    end else if (busy_r) begin
      rem_r  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_sh_r <= {q_sh_r[QUO_W-2:0], ge};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = q_sh_r;

endmodule

// ----- design/joystick_input_conditioner.sv -----
// Joystick input conditioner top level: sequencer, axis conditioning and output register.
//
// Takes one controller poll word on the in_ channel (in_valid/in_stall) and
// returns one result word on the out_ channel (out_valid/out_stall).
// Buttons are masked and edge detected; each stick axis gets a dead zone and
// an offset, then the vector length is found by a bit-serial square root and,
// if it exceeds the configured radius, both axes are rescaled by a bit-serial divider.
// With F = FRAC_BITS the root is F+8 bits wide and each quotient F+7 bits.
// A disconnected poll skips the square root and the division.
// One word at a time: in_stall is low only while idle, so the next word can be
// taken in the cycle after the result is loaded into the output register.
// The output register holds a finished word while out_stall is high; the
// block can accept and work on the next poll meanwhile, holding that result
// until the output register frees up.
// Configuration writes (cfg_we/cfg_index/cfg_wdata) take effect at once and
// are to be made while no word is in flight.
// Reset (rst_n, synchronous) empties the pipeline, restores the register
// defaults and clears the stored held-button word.
`include "joystick_input_conditioner_assert.svh"

module joystick_input_conditioner #(
  parameter int FRAC_BITS = jic_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [jic_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jic_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // poll input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  jic_pkg::in_word_t              in_word,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output jic_pkg::out_word_t             out_word
);
  import jic_pkg::*;

  localparam int ROOT_W = FRAC_BITS + 8;          // length width
  localparam int QUO_W  = FRAC_BITS + 7;          // clamped axis magnitude width
  localparam int NUM_W  = ROOT_W + QUO_W;         // |axis| * radius << 2F
  localparam int CMP_W  = (ROOT_W > 17) ? ROOT_W : 17;

  // Configuration registers
  logic [6:0]  dz_lim_r;
  logic [6:0]  offset_r;
  logic [6:0]  radius_r;
  logic [15:0] btn_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_lim_r   <= DEAD_ZONE_RST;
      offset_r   <= OFFSET_RST;
      radius_r   <= RADIUS_RST;
      btn_mask_r <= BTN_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEAD_ZONE: dz_lim_r   <= cfg_wdata[6:0];
        CFG_OFFSET:    offset_r   <= cfg_wdata[6:0];
        CFG_RADIUS:    radius_r   <= cfg_wdata[6:0];
        CFG_BTN_MASK:  btn_mask_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Dead zone and offset on one axis; the positive test wins
  function automatic logic signed [7:0] cond_axis(input logic signed [7:0] v,
                                                  input logic [6:0] lim,
                                                  input logic [6:0] off);
    logic signed [8:0] v9;
    logic signed [8:0] lim9;
    logic signed [8:0] off9;
    logic signed [8:0] r9;
    v9   = 9'(v);
    lim9 = $signed({2'b00, lim});
    off9 = $signed({2'b00, off});
    if (v9 >= lim9) begin
      r9 = v9 - off9;
    end else if (v9 <= -lim9) begin
      r9 = v9 + off9;
    end else begin
      r9 = '0;
    end
    return r9[7:0];
  endfunction

  // Signed 16-bit saturation from sign and magnitude
  function automatic logic [15:0] sat_axis(input logic neg, input logic [CMP_W-1:0] mag);
    logic [15:0] r;
    if (neg) begin
      r = (mag > CMP_W'(32768)) ? 16'h8000 : 16'(16'd0 - mag[15:0]);
    end else begin
      r = (mag > CMP_W'(32767)) ? 16'h7FFF : mag[15:0];
    end
    return r;
  endfunction

  jic_state_t state_r, state_nxt;

  // Per-word registers
  logic                 conn_r;
  logic [15:0]          held_r;
  logic [15:0]          fresh_r;
  logic [15:0]          prev_held_r;
  logic signed [7:0]    x_r;
  logic signed [7:0]    y_r;
  logic                 clamp_r;
  logic [14:0]          ax_r;
  logic [14:0]          ay_r;
  logic [QUO_W-1:0]     qx_r;

  logic                 in_fire;
  logic [15:0]          held_in;
  logic signed [15:0]   sqx;
  logic signed [15:0]   sqy;
  logic [15:0]          sum_sq;
  logic [13:0]          r_sq;
  logic [7:0]           abs_x;
  logic [7:0]           abs_y;

  ser_ctl_t             sqrt_ctl;
  ser_sts_t             sqrt_sts;
  logic [ROOT_W-1:0]    root;
  ser_ctl_t             div_ctl;
  ser_sts_t             div_sts;
  logic [NUM_W-1:0]     dividend;
  logic [QUO_W-1:0]     quotient;

  logic                 out_valid_r;
  out_word_t            out_word_r;
  out_word_t            result;
  logic                 out_load;

  assign in_stall = state_r != ST_IDLE;
  assign in_fire  = in_valid && !in_stall;
  assign held_in  = in_word.buttons_raw & btn_mask_r;

  // Squares, radius squared and magnitudes of the conditioned axes
  assign sqx    = 16'(x_r) * 16'(x_r);
  assign sqy    = 16'(y_r) * 16'(y_r);
  assign sum_sq = $unsigned(sqx) + $unsigned(sqy);
  assign r_sq   = 14'(radius_r) * 14'(radius_r);
  assign abs_x  = x_r[7] ? (8'd0 - x_r) : x_r;
  assign abs_y  = y_r[7] ? (8'd0 - y_r) : y_r;

  // Capture the poll and update the button history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_held_r <= '0;
    end else if (in_fire) begin
      prev_held_r <= in_word.connected ? held_in : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      conn_r  <= in_word.connected;
      held_r  <= held_in;
      fresh_r <= held_in & ~prev_held_r;
      x_r     <= cond_axis(in_word.raw_x, dz_lim_r, offset_r);
      y_r     <= cond_axis(in_word.raw_y, dz_lim_r, offset_r);
    end
    if (state_r == ST_PREP) begin
      clamp_r <= sum_sq > {2'b00, r_sq};
      ax_r    <= 15'(abs_x) * 15'(radius_r);
      ay_r    <= 15'(abs_y) * 15'(radius_r);
    end
    if (state_r == ST_DIV_X && div_sts.done) begin
      qx_r <= quotient;
    end
  end

  // Bit-serial units
  jic_sqrt #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sqrt_ctl),
    .radicand (sum_sq),
    .sts      (sqrt_sts),
    .root     (root)
  );

  assign dividend = (state_r == ST_SQRT) ? (NUM_W'(ax_r) << (2 * FRAC_BITS))
                                         : (NUM_W'(ay_r) << (2 * FRAC_BITS));

  jic_div #(
    .QUO_W (QUO_W),
    .DEN_W (ROOT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (dividend),
    .divisor  (root),
    .sts      (div_sts),
    .quotient (quotient)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    sqrt_ctl.start = 1'b0;
    div_ctl.start  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_word.connected ? ST_PREP : ST_DONE;
        end
      end
      ST_PREP: begin
        sqrt_ctl.start = 1'b1;
        state_nxt      = ST_SQRT;
      end
      ST_SQRT: begin
        if (sqrt_sts.done) begin
          if (clamp_r) begin
            div_ctl.start = 1'b1;
            state_nxt     = ST_DIV_X;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DIV_X: begin
        if (div_sts.done) begin
          div_ctl.start = 1'b1;
          state_nxt     = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (div_sts.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result assembly
  always_comb begin
    result = '0;
    if (conn_r) begin
      result.buttons_held = held_r;
      result.buttons_new  = fresh_r;
      if (clamp_r) begin
        result.stick_x_out = sat_axis(x_r[7], CMP_W'(qx_r));
        result.stick_y_out = sat_axis(y_r[7], CMP_W'(quotient));
        result.stick_length = ((CMP_W'(radius_r) << FRAC_BITS) > CMP_W'(32767)) ?
                              15'h7FFF : 15'((CMP_W'(radius_r) << FRAC_BITS));
      end else begin
        result.stick_x_out = sat_axis(x_r[7], CMP_W'(abs_x) << FRAC_BITS);
        result.stick_y_out = sat_axis(y_r[7], CMP_W'(abs_y) << FRAC_BITS);
        result.stick_length = (CMP_W'(root) > CMP_W'(32767)) ? 15'h7FFF : 15'(root);
      end
    end
  end

  // Output register
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Checks
  `JIC_ASSERT_CLK(a_units_exclusive, !(sqrt_sts.busy && div_sts.busy), "sqrt and divider overlap")
  `JIC_ASSERT_CLK(a_sqrt_running, (state_r != ST_SQRT) || sqrt_sts.busy || sqrt_sts.done, "sqrt wait without a running root")
  `JIC_ASSERT_CLK(a_div_only_clamped, ((state_r != ST_DIV_X) && (state_r != ST_DIV_Y)) || (clamp_r && conn_r), "division on an unclamped word")
  `JIC_ASSERT_NEXT(a_disc_clears_history, in_fire && !in_word.connected, prev_held_r == 16'd0, "history kept after disconnect")

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the joystick input conditioner: predictor, scoreboard and drivers.
`timescale 1ns / 100ps

module tb;
  import jic_pkg::*;

  localparam int FRAC       = FRAC_BITS_DEF;
  // Longest accept-to-result time (clamped poll) plus some margin
  localparam int SETTLE     = 3 * FRAC + 27 + 16;
  localparam int HOLD_LEN   = 300;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 205;
  localparam int SHOW_MAX   = 10;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;

  // Predicts conditioned words and checks them in arrival order
  class poll_scoreboard;
    logic [6:0]  dz_limit;
    logic [6:0]  offset;
    logic [6:0]  radius;
    logic [15:0] btn_mask;
    logic [15:0] prev_held;
    out_word_t   pending[$];
    int unsigned checked;
    int unsigned errors;
    int unsigned shown;

    function void restore_defaults();
      dz_limit  = DEAD_ZONE_RST;
      offset    = OFFSET_RST;
      radius    = RADIUS_RST;
      btn_mask  = BTN_MASK_RST;
      prev_held = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DEAD_ZONE: dz_limit = data[6:0];
        CFG_OFFSET:    offset   = data[6:0];
        CFG_RADIUS:    radius   = data[6:0];
        CFG_BTN_MASK:  btn_mask = data[15:0];
        default: ;
      endcase
    endfunction

    // Dead zone, then pull toward zero; the positive test wins when both hold
    function longint trim_axis(longint v);
      longint lim;
      longint off;
      longint r;
      lim = dz_limit;
      off = offset;
      r   = 0;
      if (v <= -lim) r = v + off;
      if (v >= lim)  r = v - off;
      return r;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe >>= 2;
      while (probe != 0) begin
        if (n >= root + probe) begin
          n    -= root + probe;
          root  = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    function longint rescale(longint a, longint unsigned num, longint unsigned len);
      longint unsigned mag;
      longint unsigned q;
      mag = (a < 0) ? -a : a;
      q   = (mag * num) / len;
      return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function logic [15:0] sat_axis(longint v);
      if (v > 32767)  v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function logic [14:0] sat_length(longint unsigned v);
      return (v > 32767) ? 15'h7FFF : v[14:0];
    endfunction

    function void note_poll(in_word_t w);
      out_word_t       exp_w;
      logic [15:0]     held;
      longint          x;
      longint          y;
      longint          xo;
      longint          yo;
      longint unsigned s;
      longint unsigned len;
      longint unsigned r2;
      longint unsigned num;
      longint unsigned one;
      exp_w = '0;
      // Disconnected poll: zero word, forget held buttons
      if (!w.connected) begin
        prev_held = '0;
        pending.push_back(exp_w);
        return;
      end
      held      = w.buttons_raw & btn_mask;
      exp_w.buttons_held = held;
      exp_w.buttons_new  = held & ~prev_held;
      prev_held = held;

      x   = trim_axis(longint'($signed(w.raw_x)));
      y   = trim_axis(longint'($signed(w.raw_y)));
      one = 64'd1 << FRAC;
      s   = x * x + y * y;
      len = int_sqrt(s << (2 * FRAC));
      r2  = longint'(radius) * longint'(radius);
      if (s > r2) begin
        num = longint'(radius) * one * one;
        xo  = rescale(x, num, len);
        yo  = rescale(y, num, len);
        len = longint'(radius) * one;
      end else begin
        xo = x * longint'(one);
        yo = y * longint'(one);
      end
      exp_w.stick_x_out  = sat_axis(xo);
      exp_w.stick_y_out  = sat_axis(yo);
      exp_w.stick_length = sat_length(len);
      pending.push_back(exp_w);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        errors++;
        if (shown < SHOW_MAX) begin
          shown++;
          $display("unexpected result word %h at %0t", got, $realtime);
        end
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.buttons_held !== want.buttons_held || got.buttons_new !== want.buttons_new ||
          got.stick_x_out !== want.stick_x_out || got.stick_y_out !== want.stick_y_out ||
          got.stick_length !== want.stick_length) begin
        errors++;
        if (shown < SHOW_MAX) begin
          shown++;
          $display("mismatch on word %0d at %0t", checked, $realtime);
          $display("  exp held=%h new=%h x=%0d y=%0d len=%0d", want.buttons_held,
                   want.buttons_new, want.stick_x_out, want.stick_y_out, want.stick_length);
          $display("  got held=%h new=%h x=%0d y=%0d len=%0d", got.buttons_held,
                   got.buttons_new, got.stick_x_out, got.stick_y_out, got.stick_length);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_word;

  poll_scoreboard sb;

  int unsigned polls_taken;
  int unsigned settings_done;
  int unsigned holds_done;
  int unsigned idle_cycles;
  int unsigned burst_left;
  bit          gaps_on;
  bit          hold_req;
  logic [15:0] last_buttons;
  rx_mode_t    rx_mode;
  int unsigned rx_left;

  joystick_input_conditioner uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Monitor both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid && !in_stall) begin
        sb.note_poll(in_word);
        polls_taken++;
      end
      if (out_valid && !out_stall) sb.check_result(out_word);
    end
  end

  // Watchdog: cycles with no transfer and no register write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no activity for %0d cycles, %0d words pending",
               idle_cycles, sb.pending.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stall pattern, with an occasional long hold-off on request
  always begin
    @(negedge clk);
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (HOLD_LEN) @(negedge clk);
      hold_req = 1'b0;
      holds_done++;
    end else begin
      if (rx_left == 0) begin
        case ($urandom_range(0, 3))
          0, 1:    rx_mode = RX_FREE;
          2:       rx_mode = RX_LIGHT;
          default: rx_mode = RX_HEAVY;
        endcase
        rx_left = $urandom_range(16, 200);
      end
      rx_left--;
      case (rx_mode)
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= 1'b0;
      endcase
    end
  end

  function automatic in_word_t poll_word(logic c, int x, int y, logic [15:0] b);
    in_word_t w;
    w.connected   = c;
    w.raw_x       = x[7:0];
    w.raw_y       = y[7:0];
    w.buttons_raw = b;
    return w;
  endfunction

  // One raw axis value: full range, around the dead zone edge, near zero, zero or extremes
  function automatic int rand_axis();
    int v;
    case ($urandom_range(0, 7))
      4: begin
        v = int'(sb.dz_limit) + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) v = -v;
        if (v > 127)  v = 127;
        if (v < -128) v = -128;
      end
      5:       v = 0;
      6:       v = $urandom_range(0, 1) ? 127 : -128;
      7:       v = $urandom_range(0, 40) - 20;
      default: v = $urandom_range(0, 255) - 128;
    endcase
    return v;
  endfunction

  function automatic in_word_t next_poll();
    logic [15:0] b;
    if ($urandom_range(0, 1)) b = $urandom_range(0, 65535);
    else                      b = last_buttons ^ (16'd1 << $urandom_range(0, 15));
    last_buttons = b;
    return poll_word($urandom_range(0, 15) != 0, rand_axis(), rand_axis(), b);
  endfunction

  // Offer one word, wait for it to be taken, then maybe pause between bursts
  task automatic send_poll(in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (burst_left != 0) burst_left--;
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // Drain: nothing outstanding, then the worst-case latency once more
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write all four registers; upper data bits are random where unused
  task automatic program_regs(logic [6:0] dz, logic [6:0] off, logic [6:0] rad,
                              logic [15:0] mask);
    logic [CFG_DATA_W-1:0] vals[4];
    vals[0] = {9'($urandom_range(0, 511)), dz};
    vals[1] = {9'($urandom_range(0, 511)), off};
    vals[2] = {9'($urandom_range(0, 511)), rad};
    vals[3] = mask;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(negedge clk);
      sb.write_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_done++;
  endtask

  function automatic logic [6:0] pick7(int lo);
    case ($urandom_range(0, 5))
      0:       return 7'(lo);
      1:       return 7'd127;
      default: return 7'($urandom_range(lo, 40));
    endcase
  endfunction

  initial begin
    logic [15:0] mask;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_word      = '0;
    out_stall    = 1'b0;
    hold_req     = 1'b0;
    gaps_on      = 1'b1;
    burst_left   = 0;
    idle_cycles  = 0;
    rx_left      = 0;
    rx_mode      = RX_FREE;
    last_buttons = '0;
    sb = new();
    sb.restore_defaults();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset settings, dead zone edges, clamp edge, disconnect
    send_poll(poll_word(1, 0, 0, 16'h0000));
    send_poll(poll_word(1, 127, 127, 16'hFFFF));
    send_poll(poll_word(1, -128, -128, 16'hFFFF));
    send_poll(poll_word(1, 7, -7, 16'h00FF));
    send_poll(poll_word(1, 8, -8, 16'hFF00));
    send_poll(poll_word(1, -9, 9, 16'hFF00));
    send_poll(poll_word(0, 55, -55, 16'hFFFF));
    send_poll(poll_word(1, 0, 0, 16'hFFFF));
    send_poll(poll_word(1, 70, 0, 16'hAAAA));   // length exactly at radius
    send_poll(poll_word(1, 71, 0, 16'h5555));   // just over
    send_poll(poll_word(1, 0, -71, 16'h0001));
    send_poll(poll_word(1, -128, 127, 16'h8000));
    settle();

    // Zero dead zone, offset past the limit, zero radius, all buttons masked
    program_regs(7'd0, 7'd127, 7'd0, 16'h0000);
    send_poll(poll_word(1, 0, 0, 16'hFFFF));
    send_poll(poll_word(1, 1, -1, 16'h1234));
    settle();

    program_regs(7'd127, 7'd0, 7'd127, 16'hFFFF);
    send_poll(poll_word(1, 127, -127, 16'hFFFF));
    send_poll(poll_word(1, -128, 0, 16'h0000));
    send_poll(poll_word(1, 126, 126, 16'hF0F0));
    send_poll(poll_word(1, -127, 127, 16'h0F0F));
    settle();

    // Pulled values cross zero
    program_regs(7'd0, 7'd127, 7'd127, 16'h00F0);
    send_poll(poll_word(1, 1, -1, 16'h00FF));
    send_poll(poll_word(1, 0, 5, 16'h00F0));
    send_poll(poll_word(1, -128, -128, 16'h0000));
    settle();

    program_regs(7'd1, 7'd0, 7'd1, 16'hFFFF);
    send_poll(poll_word(1, 1, 0, 16'h0003));
    send_poll(poll_word(1, 1, 1, 16'h0007));
    send_poll(poll_word(1, -1, 0, 16'h0000));
    settle();

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 3))
        0:       mask = 16'hFFFF;
        1:       mask = 16'h0000;
        default: mask = $urandom_range(0, 65535);
      endcase
      if (p == 0) program_regs(DEAD_ZONE_RST, OFFSET_RST, RADIUS_RST, BTN_MASK_RST);
      else        program_regs(pick7(1), pick7(0), pick7(1), mask);
      gaps_on = (p % 3) != 2;
      if (p == 3) begin
        gaps_on  = 1'b0;
        hold_req = 1'b1;
      end
      for (int i = 0; i < PHASE_LEN; i++) send_poll(next_poll());
      settle();
    end

    $display("%0d polls taken and %0d results checked over %0d register settings",
             polls_taken, sb.checked, settings_done);
    $display("%0d long output hold-offs with the input kept busy", holds_done);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d errors, %0d results never arrived", sb.errors, sb.pending.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
